>>> rtl/bfd_pkg.sv
// Shared types and constants for the box filter downscaler.
// Holds payload structs, state enums and register indexes; no dependencies.
`timescale 1ns / 1ps
package bfd_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 2048;
  localparam int unsigned DEF_MAX_HEIGHT   = 2048;
  localparam int unsigned DEF_MAX_CHANNELS = 4;

  localparam int unsigned PIX_CH      = 4;
  localparam int unsigned CFG_W       = 12;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned COORD_W     = 11;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd4;

  typedef struct packed {
    logic [7:0] in_channel3;
    logic [7:0] in_channel2;
    logic [7:0] in_channel1;
    logic [7:0] in_channel0;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_channel0;
    logic [7:0]         out_channel1;
    logic [7:0]         out_channel2;
    logic [7:0]         out_channel3;
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic               frame_done;
  } out_item_t;

  typedef enum logic [1:0] {
    FS_LOAD,
    FS_SETUP,
    FS_IDLE,
    FS_ACC
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_HOLD
  } back_state_t;

endpackage

>>> rtl/box_filter_image_downscaler_core.sv
// Box filter downscaler: a pixel is accepted and then accumulated, and no new pixel is taken
// until the read-modify-write of the column sum memory is done. A finished bin is averaged
// by a bit-serial divider, and the back takes no new bin until its result has been popped;
// a two-entry queue between the halves absorbs bursts. A result passes from the accumulate
// state through the queue and the divider to the hold state. After reset and after each write
// to a valid register index the bin steps are recomputed while full is high.
// Depends on bfd_pkg, bfd_front, bfd_fifo and bfd_back.
`timescale 1ns / 1ps
module box_filter_image_downscaler_core #(
  parameter int unsigned MAX_WIDTH    = bfd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = bfd_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = bfd_pkg::DEF_MAX_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_push,
  input  bfd_pkg::in_item_t             in_data,
  output logic                          in_full,
  output bfd_pkg::out_item_t            out_data,
  output logic                          out_empty,
  input  logic                          out_pop
);
  import bfd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned SUM_W = 8 + AW;
  localparam int unsigned EW    = PIX_CH * SUM_W + AW + 2 * COORD_W + 1;

  logic          f_push, f_full, b_pop, b_empty;
  logic [EW-1:0] f_data, b_data;

  bfd_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .EW           (EW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_push    (f_push),
    .q_data    (f_data),
    .q_full    (f_full)
  );

  bfd_fifo #(
    .WIDTH (EW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_data (f_data),
    .full      (f_full),
    .pop       (b_pop),
    .pop_data  (b_data),
    .empty     (b_empty)
  );

  bfd_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .EW         (EW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (b_data),
    .q_empty   (b_empty),
    .q_pop     (b_pop),
    .out_data  (out_data),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

>>> rtl/bfd_fifo.sv
// Two-entry queue between the accumulating front and the averaging back.
// Depends on bfd_pkg for the queue depth.
`timescale 1ns / 1ps
module bfd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  import bfd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] store_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/bfd_front.sv
// Front of the downscaler: configuration, bin tracking and column sum memory.
// Depends on bfd_pkg; feeds finished bins into the queue toward bfd_back.
`timescale 1ns / 1ps
module bfd_front #(
  parameter int unsigned MAX_WIDTH    = bfd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = bfd_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = bfd_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned EW           = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_push,
  input  bfd_pkg::in_item_t              in_data,
  output logic                           in_full,
  output logic                           q_push,
  output logic [EW-1:0]                  q_data,
  input  logic                           q_full
);
  import bfd_pkg::*;

  localparam int unsigned CW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DW     = (CW > RW) ? CW : RW;
  localparam int unsigned AX     = $clog2(MAX_WIDTH);
  localparam int unsigned AW     = CW + RW;
  localparam int unsigned SUM_W  = 8 + AW;
  localparam int unsigned STEP_W = $clog2(DW + 1);
  localparam int unsigned LANE_W = MAX_CHANNELS * SUM_W;

  front_state_t state_r, state_nxt;

  logic [CFG_W-1:0] cfg_sw_r, cfg_sh_r, cfg_tw_r, cfg_th_r;
  logic [2:0]       cfg_nch_r;
  logic             cfg_hit;

  logic [CW-1:0] sw_eff, tw_eff;
  logic [RW-1:0] sh_eff, th_eff;
  logic [2:0]    nch_eff;

  logic [DW-1:0]     dx_dvd_r, dx_rem_r, dx_quo_r, dy_dvd_r, dy_rem_r, dy_quo_r;
  logic [DW-1:0]     dx_rem_nxt, dx_quo_nxt, dy_rem_nxt, dy_quo_nxt;
  logic [DW:0]       dx_sh, dy_sh;
  logic [STEP_W-1:0] step_r;
  logic              setup_last;

  logic [CW-1:0] sc_r, tc_r, cstart_r, cedge_r, cres_r;
  logic [RW-1:0] sr_r, tr_r, rstart_r, redge_r, rres_r;
  logic [CW-1:0] sc_nxt, tc_nxt, cstart_nxt, cedge_nxt, cres_nxt;
  logic [RW-1:0] sr_nxt, tr_nxt, rstart_nxt, redge_nxt, rres_nxt;
  logic [CW-1:0] qx, rx;
  logic [RW-1:0] qy, ry;
  logic [CW:0]   sc1, cedge_a, cres_a;
  logic [RW:0]   sr1, redge_a, rres_a;
  logic          col_end, row_end, emit, row_first, frame_last;

  logic [LANE_W-1:0] mem [MAX_WIDTH];
  logic [LANE_W-1:0] rd_r, wr_data;
  in_item_t          pix_r;
  logic [7:0]        pix [PIX_CH];
  logic [SUM_W-1:0]  new_sum [PIX_CH];
  logic [SUM_W-1:0]  out_sum [PIX_CH];
  logic [AW-1:0]     area;
  logic [31:0]       col_wide, row_wide;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index <= REG_CHANNEL_COUNT);
  assign accept    = in_push && !in_full;

  always_comb begin
    if (cfg_sw_r == '0) begin
      sw_eff = CW'(1);
    end else if (32'(cfg_sw_r) > MAX_WIDTH) begin
      sw_eff = CW'(MAX_WIDTH);
    end else begin
      sw_eff = CW'(cfg_sw_r);
    end
    if (cfg_sh_r == '0) begin
      sh_eff = RW'(1);
    end else if (32'(cfg_sh_r) > MAX_HEIGHT) begin
      sh_eff = RW'(MAX_HEIGHT);
    end else begin
      sh_eff = RW'(cfg_sh_r);
    end
    if (cfg_tw_r == '0) begin
      tw_eff = CW'(1);
    end else if (32'(cfg_tw_r) > 32'(sw_eff)) begin
      tw_eff = sw_eff;
    end else begin
      tw_eff = CW'(cfg_tw_r);
    end
    if (cfg_th_r == '0) begin
      th_eff = RW'(1);
    end else if (32'(cfg_th_r) > 32'(sh_eff)) begin
      th_eff = sh_eff;
    end else begin
      th_eff = RW'(cfg_th_r);
    end
    if (cfg_nch_r == '0) begin
      nch_eff = 3'd1;
    end else if (32'(cfg_nch_r) > MAX_CHANNELS) begin
      nch_eff = 3'(MAX_CHANNELS);
    end else begin
      nch_eff = cfg_nch_r;
    end
  end

  // One restoring division step per cycle for both bin quotients.
  always_comb begin
    dx_sh = {dx_rem_r, dx_dvd_r[DW-1]};
    dy_sh = {dy_rem_r, dy_dvd_r[DW-1]};
    if (dx_sh >= (DW+1)'(tw_eff)) begin
      dx_rem_nxt = DW'(dx_sh - (DW+1)'(tw_eff));
      dx_quo_nxt = {dx_quo_r[DW-2:0], 1'b1};
    end else begin
      dx_rem_nxt = DW'(dx_sh);
      dx_quo_nxt = {dx_quo_r[DW-2:0], 1'b0};
    end
    if (dy_sh >= (DW+1)'(th_eff)) begin
      dy_rem_nxt = DW'(dy_sh - (DW+1)'(th_eff));
      dy_quo_nxt = {dy_quo_r[DW-2:0], 1'b1};
    end else begin
      dy_rem_nxt = DW'(dy_sh);
      dy_quo_nxt = {dy_quo_r[DW-2:0], 1'b0};
    end
  end

  assign setup_last = (step_r == STEP_W'(DW - 1));
  assign qx = CW'(dx_quo_r);
  assign rx = CW'(dx_rem_r);
  assign qy = RW'(dy_quo_r);
  assign ry = RW'(dy_rem_r);

  always_comb begin
    sc1       = {1'b0, sc_r} + (CW+1)'(1);
    sr1       = {1'b0, sr_r} + (RW+1)'(1);
    col_end   = (sc1 == {1'b0, cedge_r});
    row_end   = (sr1 == {1'b0, redge_r});
    emit      = col_end && row_end;
    row_first = (sr_r == rstart_r) && (sc_r == cstart_r);
    frame_last = ({1'b0, tc_r} + (CW+1)'(1) == {1'b0, tw_eff}) &&
                 ({1'b0, tr_r} + (RW+1)'(1) == {1'b0, th_eff});

    cedge_a = {1'b0, cedge_r} + {1'b0, qx};
    cres_a  = {1'b0, cres_r} + {1'b0, rx};
    if (cres_a >= {1'b0, tw_eff}) begin
      cres_a  = cres_a - {1'b0, tw_eff};
      cedge_a = cedge_a + (CW+1)'(1);
    end
    redge_a = {1'b0, redge_r} + {1'b0, qy};
    rres_a  = {1'b0, rres_r} + {1'b0, ry};
    if (rres_a >= {1'b0, th_eff}) begin
      rres_a  = rres_a - {1'b0, th_eff};
      redge_a = redge_a + (RW+1)'(1);
    end

    sc_nxt     = CW'(sc1);
    tc_nxt     = tc_r;
    cstart_nxt = cstart_r;
    cedge_nxt  = cedge_r;
    cres_nxt   = cres_r;
    sr_nxt     = sr_r;
    tr_nxt     = tr_r;
    rstart_nxt = rstart_r;
    redge_nxt  = redge_r;
    rres_nxt   = rres_r;
    if (col_end) begin
      tc_nxt     = tc_r + CW'(1);
      cstart_nxt = cedge_r;
      cedge_nxt  = CW'(cedge_a);
      cres_nxt   = CW'(cres_a);
    end
    if (sc1 >= {1'b0, sw_eff}) begin
      sc_nxt     = '0;
      tc_nxt     = '0;
      cstart_nxt = '0;
      cedge_nxt  = qx;
      cres_nxt   = rx;
      sr_nxt     = RW'(sr1);
      if (row_end) begin
        tr_nxt     = tr_r + RW'(1);
        rstart_nxt = redge_r;
        redge_nxt  = RW'(redge_a);
        rres_nxt   = RW'(rres_a);
      end
      if (sr1 >= {1'b0, sh_eff}) begin
        sr_nxt     = '0;
        tr_nxt     = '0;
        rstart_nxt = '0;
        redge_nxt  = qy;
        rres_nxt   = ry;
      end
    end
  end

  // The first pixel of each bin starts its sum from zero, so stale memory contents never
  // need clearing.
  assign pix[0] = pix_r.in_channel0;
  assign pix[1] = pix_r.in_channel1;
  assign pix[2] = pix_r.in_channel2;
  assign pix[3] = pix_r.in_channel3;

  for (genvar c = 0; c < PIX_CH; c++) begin : g_lane
    if (c < MAX_CHANNELS) begin : g_used
      logic [SUM_W-1:0] base;
      assign base = row_first ? '0 : rd_r[c*SUM_W +: SUM_W];
      assign new_sum[c] = (3'(c) < nch_eff) ? base + SUM_W'(pix[c]) : base;
      assign out_sum[c] = (3'(c) < nch_eff) ? new_sum[c] : '0;
      assign wr_data[c*SUM_W +: SUM_W] = new_sum[c];
    end else begin : g_unused
      assign new_sum[c] = '0;
      assign out_sum[c] = '0;
    end
  end

  assign area     = AW'(cedge_r - cstart_r) * AW'(redge_r - rstart_r);
  assign col_wide = 32'(tc_r);
  assign row_wide = 32'(tr_r);
  assign q_data   = {out_sum[0], out_sum[1], out_sum[2], out_sum[3], area,
                     col_wide[COORD_W-1:0], row_wide[COORD_W-1:0], frame_last};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_LOAD: begin
        state_nxt = FS_SETUP;
      end
      FS_SETUP: begin
        if (setup_last) begin
          state_nxt = FS_IDLE;
        end
      end
      FS_IDLE: begin
        if (accept) begin
          state_nxt = FS_ACC;
        end
      end
      FS_ACC: begin
        state_nxt = FS_IDLE;
      end
      default: begin
        state_nxt = FS_LOAD;
      end
    endcase
    if (cfg_hit) begin
      state_nxt = FS_LOAD;
    end
  end

  always_comb begin
    in_full = !((state_r == FS_IDLE) && !q_full);
    q_push  = (state_r == FS_ACC) && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FS_LOAD;
      cfg_sw_r  <= CFG_W'(2);
      cfg_sh_r  <= CFG_W'(2);
      cfg_tw_r  <= CFG_W'(1);
      cfg_th_r  <= CFG_W'(1);
      cfg_nch_r <= 3'd4;
      step_r    <= '0;
      sc_r      <= '0;
      tc_r      <= '0;
      cstart_r  <= '0;
      cedge_r   <= '0;
      cres_r    <= '0;
      sr_r      <= '0;
      tr_r      <= '0;
      rstart_r  <= '0;
      redge_r   <= '0;
      rres_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_hit) begin
        unique case (cfg_index)
          REG_SOURCE_WIDTH:  cfg_sw_r  <= cfg_data;
          REG_SOURCE_HEIGHT: cfg_sh_r  <= cfg_data;
          REG_TARGET_WIDTH:  cfg_tw_r  <= cfg_data;
          REG_TARGET_HEIGHT: cfg_th_r  <= cfg_data;
          default:           cfg_nch_r <= cfg_data[2:0];
        endcase
      end
      if (state_r == FS_LOAD) begin
        step_r <= '0;
      end else if (state_r == FS_SETUP) begin
        step_r <= step_r + STEP_W'(1);
        if (setup_last) begin
          sc_r     <= '0;
          tc_r     <= '0;
          cstart_r <= '0;
          cedge_r  <= CW'(dx_quo_nxt);
          cres_r   <= CW'(dx_rem_nxt);
          sr_r     <= '0;
          tr_r     <= '0;
          rstart_r <= '0;
          redge_r  <= RW'(dy_quo_nxt);
          rres_r   <= RW'(dy_rem_nxt);
        end
      end else if (state_r == FS_ACC) begin
        sc_r     <= sc_nxt;
        tc_r     <= tc_nxt;
        cstart_r <= cstart_nxt;
        cedge_r  <= cedge_nxt;
        cres_r   <= cres_nxt;
        sr_r     <= sr_nxt;
        tr_r     <= tr_nxt;
        rstart_r <= rstart_nxt;
        redge_r  <= redge_nxt;
        rres_r   <= rres_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == FS_LOAD) begin
      dx_dvd_r <= DW'(sw_eff);
      dy_dvd_r <= DW'(sh_eff);
      dx_rem_r <= '0;
      dy_rem_r <= '0;
      dx_quo_r <= '0;
      dy_quo_r <= '0;
    end else if (state_r == FS_SETUP) begin
      dx_dvd_r <= {dx_dvd_r[DW-2:0], 1'b0};
      dy_dvd_r <= {dy_dvd_r[DW-2:0], 1'b0};
      dx_rem_r <= dx_rem_nxt;
      dy_rem_r <= dy_rem_nxt;
      dx_quo_r <= dx_quo_nxt;
      dy_quo_r <= dy_quo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= in_data;
      rd_r  <= mem[tc_r[AX-1:0]];
    end
    if (state_r == FS_ACC) begin
      mem[tc_r[AX-1:0]] <= wr_data;
    end
  end

endmodule

>>> rtl/bfd_back.sv
// Back of the downscaler: divides bin sums by the bin area, one quotient bit a cycle.
// Depends on bfd_pkg; takes jobs from the queue and holds the result for the consumer.
`timescale 1ns / 1ps
module bfd_back #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = bfd_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned EW         = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [EW-1:0]      q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output bfd_pkg::out_item_t out_data,
  output logic               out_empty,
  input  logic               out_pop
);
  import bfd_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AW    = CW + RW;
  localparam int unsigned SUM_W = 8 + AW;
  localparam int unsigned DV_W  = AW + 7;

  back_state_t state_r, state_nxt;

  logic [SUM_W-1:0]   in_sum [PIX_CH];
  logic [AW-1:0]      in_area;
  logic [COORD_W-1:0] in_col, in_row;
  logic               in_done;

  logic [SUM_W-1:0]   rem_r [PIX_CH];
  logic [SUM_W-1:0]   rem_nxt [PIX_CH];
  logic [7:0]         quo_r [PIX_CH];
  logic [7:0]         quo_nxt [PIX_CH];
  logic [DV_W-1:0]    dv_r;
  logic [2:0]         bit_r;
  logic [COORD_W-1:0] col_r, row_r;
  logic               done_r;

  assign {in_sum[0], in_sum[1], in_sum[2], in_sum[3], in_area, in_col, in_row, in_done} = q_data;

  always_comb begin
    for (int c = 0; c < PIX_CH; c++) begin
      if (rem_r[c] >= SUM_W'(dv_r)) begin
        rem_nxt[c] = rem_r[c] - SUM_W'(dv_r);
        quo_nxt[c] = {quo_r[c][6:0], 1'b1};
      end else begin
        rem_nxt[c] = rem_r[c];
        quo_nxt[c] = {quo_r[c][6:0], 1'b0};
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          state_nxt = BS_DIV;
        end
      end
      BS_DIV: begin
        if (bit_r == 3'd7) begin
          state_nxt = BS_HOLD;
        end
      end
      BS_HOLD: begin
        if (out_pop) begin
          state_nxt = BS_IDLE;
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop     = (state_r == BS_IDLE) && !q_empty;
    out_empty = (state_r != BS_HOLD);
    out_data.out_channel0 = quo_r[0];
    out_data.out_channel1 = quo_r[1];
    out_data.out_channel2 = quo_r[2];
    out_data.out_channel3 = quo_r[3];
    out_data.out_column   = col_r;
    out_data.out_row      = row_r;
    out_data.frame_done   = done_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BS_IDLE) begin
        bit_r <= '0;
      end else if (state_r == BS_DIV) begin
        bit_r <= bit_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int c = 0; c < PIX_CH; c++) begin
        rem_r[c] <= in_sum[c];
        quo_r[c] <= '0;
      end
      dv_r   <= {in_area, 7'b0};
      col_r  <= in_col;
      row_r  <= in_row;
      done_r <= in_done;
    end else if (state_r == BS_DIV) begin
      for (int c = 0; c < PIX_CH; c++) begin
        rem_r[c] <= rem_nxt[c];
        quo_r[c] <= quo_nxt[c];
      end
      dv_r <= dv_r >> 1;
    end
  end

endmodule

>>> test/box_filter_image_downscaler_core_test.sv
// Self-checking testbench for the box filter image downscaler core.
// Streams random and directed pixels, predicts each averaged output pixel and
// compares every field. Depends on bfd_pkg and box_filter_image_downscaler_core.
`timescale 1ns / 1ps
module box_filter_image_downscaler_core_test;
  import bfd_pkg::*;

  localparam int unsigned WIDTH_MAX = 2048;
  localparam int unsigned HEIGHT_MAX = 2048;
  localparam int unsigned CHAN_MAX = 4;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_push;
  in_item_t in_data;
  logic in_full;
  out_item_t out_data;
  logic out_empty;
  logic out_pop;

  box_filter_image_downscaler_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_data(out_data), .out_empty(out_empty), .out_pop(out_pop)
  );

  // Predictor state.
  int unsigned reg_val [5];
  longint unsigned col_sums [WIDTH_MAX*CHAN_MAX];
  int unsigned src_col, src_row, dst_col, dst_row;
  int unsigned col_end, row_end, col_rem, row_rem, col_begin, row_begin;
  int unsigned eff_sw, eff_sh, eff_tw, eff_th, eff_ch, step_x, rem_x, step_y, rem_y;

  out_item_t pixels_due [$];
  int unsigned errors = 0;
  int unsigned pixels_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned stall_cycles = 0;
  bit steady = 0;

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    eff_sw = clamp(reg_val[REG_SOURCE_WIDTH], 1, WIDTH_MAX);
    eff_sh = clamp(reg_val[REG_SOURCE_HEIGHT], 1, HEIGHT_MAX);
    eff_tw = clamp(reg_val[REG_TARGET_WIDTH], 1, eff_sw);
    eff_th = clamp(reg_val[REG_TARGET_HEIGHT], 1, eff_sh);
    eff_ch = clamp(reg_val[REG_CHANNEL_COUNT], 1, CHAN_MAX);
    step_x = eff_sw / eff_tw;
    rem_x = eff_sw % eff_tw;
    step_y = eff_sh / eff_th;
    rem_y = eff_sh % eff_th;
    foreach (col_sums[i]) col_sums[i] = 0;
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
    col_begin = 0; col_end = step_x; col_rem = rem_x;
    row_begin = 0; row_end = step_y; row_rem = rem_y;
  endfunction

  function automatic void reset_registers();
    reg_val[REG_SOURCE_WIDTH] = 2;
    reg_val[REG_SOURCE_HEIGHT] = 2;
    reg_val[REG_TARGET_WIDTH] = 1;
    reg_val[REG_TARGET_HEIGHT] = 1;
    reg_val[REG_CHANNEL_COUNT] = 4;
    restart_frame();
  endfunction

  function automatic void apply_register(int unsigned idx, int unsigned val);
    if (idx > REG_CHANNEL_COUNT) return;
    reg_val[idx] = (idx == REG_CHANNEL_COUNT) ? (val & 7) : (val & 12'hfff);
    restart_frame();
  endfunction

  function automatic void queue_result(out_item_t res);
    pixels_due.insert(pixels_due.size(), res);
  endfunction

  function automatic bit average_pixel(in_item_t px, output out_item_t res);
    int unsigned col;
    int unsigned base;
    logic [7:0] chan [4];
    logic [7:0] avg [4];
    longint unsigned area;
    bit hit;
    chan[0] = px.in_channel0; chan[1] = px.in_channel1;
    chan[2] = px.in_channel2; chan[3] = px.in_channel3;
    col = (dst_col < WIDTH_MAX) ? dst_col : WIDTH_MAX - 1;
    base = col * CHAN_MAX;
    hit = 0;
    res = '0;
    for (int c = 0; c < eff_ch; c++) col_sums[base+c] += chan[c];
    if (src_col + 1 == col_end && src_row + 1 == row_end) begin
      area = longint'(col_end - col_begin) * longint'(row_end - row_begin);
      if (area == 0) area = 1;
      for (int c = 0; c < 4; c++) begin
        avg[c] = 0;
        if (c < eff_ch) begin
          avg[c] = 8'(col_sums[base+c] / area);
          col_sums[base+c] = 0;
        end
      end
      res.out_channel0 = avg[0];
      res.out_channel1 = avg[1];
      res.out_channel2 = avg[2];
      res.out_channel3 = avg[3];
      res.out_column = COORD_W'(dst_col);
      res.out_row = COORD_W'(dst_row);
      res.frame_done = (dst_col + 1 == eff_tw && dst_row + 1 == eff_th);
      hit = 1;
    end
    src_col++;
    if (src_col == col_end) begin
      dst_col++;
      col_begin = col_end;
      col_end += step_x;
      col_rem += rem_x;
      if (col_rem >= eff_tw) begin
        col_rem -= eff_tw;
        col_end++;
      end
    end
    if (src_col >= eff_sw) begin
      src_col = 0; dst_col = 0;
      col_begin = 0; col_end = step_x; col_rem = rem_x;
      src_row++;
      if (src_row == row_end) begin
        dst_row++;
        row_begin = row_end;
        row_end += step_y;
        row_rem += rem_y;
        if (row_rem >= eff_th) begin
          row_rem -= eff_th;
          row_end++;
        end
      end
      if (src_row >= eff_sh) begin
        src_row = 0; dst_row = 0;
        row_begin = 0; row_end = step_y; row_rem = rem_y;
      end
    end
    return hit;
  endfunction

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  task automatic wait_drained();
    in_push <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(int unsigned idx, int unsigned val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(idx);
    cfg_data <= CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
    reg_writes++;
  endtask

  task automatic send_pixel(in_item_t px);
    out_item_t res;
    if (!steady && $urandom_range(99) < 30) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_full);
    pixels_sent++;
    if (average_pixel(px, res)) queue_result(res);
  endtask

  function automatic in_item_t random_pixel();
    return in_item_t'($urandom);
  endfunction

  task automatic set_geometry(int unsigned sw, int unsigned sh, int unsigned tw,
                              int unsigned th, int unsigned ch);
    write_register(REG_SOURCE_WIDTH, sw);
    write_register(REG_SOURCE_HEIGHT, sh);
    write_register(REG_TARGET_WIDTH, tw);
    write_register(REG_TARGET_HEIGHT, th);
    write_register(REG_CHANNEL_COUNT, ch);
  endtask

  task automatic send_frame();
    for (int i = 0; i < eff_sw * eff_sh; i++) send_pixel(random_pixel());
  endtask

  task automatic test_reset_geometry();
    send_pixel('1);
    send_pixel('1);
    send_pixel('0);
    send_pixel('1);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    send_pixel(random_pixel());
  endtask

  task automatic test_clamped_registers();
    set_geometry(0, 0, 0, 0, 0);
    send_pixel('1);
    send_pixel(random_pixel());
    set_geometry(3, 2, 4095, 4095, 7);
    send_frame();
    set_geometry(3, 3, 2, 1, 5);
    send_frame();
    write_register(5, 4095);
    write_register(7, 0);
    send_pixel('1);
    set_geometry(3, 1, 3, 1, 2);
    send_frame();
  endtask

  task automatic test_full_width_row();
    set_geometry(4095, 1, 16, 1, 4);
    for (int i = 0; i < 256; i++) send_pixel('1);
    set_geometry(2048, 1, 2048, 1, 1);
    for (int i = 0; i < 16; i++) send_pixel(random_pixel());
  endtask

  task automatic test_random_frames(int unsigned budget);
    int unsigned stop;
    int unsigned sw;
    int unsigned sh;
    stop = pixels_sent + budget;
    while (pixels_sent < stop) begin
      sw = $urandom_range(12, 1);
      sh = $urandom_range(8, 1);
      set_geometry(($urandom_range(19) == 0) ? 0 : sw, sh, $urandom_range(sw, 1),
                   $urandom_range(sh, 1), $urandom_range(7));
      if ($urandom_range(9) < 8) begin
        repeat ($urandom_range(2, 1)) send_frame();
      end else begin
        repeat ($urandom_range(eff_sw * eff_sh, 1)) send_pixel(random_pixel());
      end
      if ($urandom_range(9) == 0) begin
        wait_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    steady = 1;
    set_geometry(8, 4, 3, 2, 4);
    repeat (3) send_frame();
    set_geometry(5, 5, 5, 5, 3);
    send_frame();
    steady = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pixels_due.size() == 0) begin
          $error("output pixel with none expected: %p", out_data);
          errors++;
        end else begin
          out_item_t exp_px;
          exp_px = pixels_due.pop_front();
          pixels_checked++;
          if (exp_px.out_channel0 !== out_data.out_channel0) begin
            $error("out_channel0 expected %0d got %0d", exp_px.out_channel0,
                   out_data.out_channel0);
            errors++;
          end
          if (exp_px.out_channel1 !== out_data.out_channel1) begin
            $error("out_channel1 expected %0d got %0d", exp_px.out_channel1,
                   out_data.out_channel1);
            errors++;
          end
          if (exp_px.out_channel2 !== out_data.out_channel2) begin
            $error("out_channel2 expected %0d got %0d", exp_px.out_channel2,
                   out_data.out_channel2);
            errors++;
          end
          if (exp_px.out_channel3 !== out_data.out_channel3) begin
            $error("out_channel3 expected %0d got %0d", exp_px.out_channel3,
                   out_data.out_channel3);
            errors++;
          end
          if (exp_px.out_column !== out_data.out_column) begin
            $error("out_column expected %0d got %0d", exp_px.out_column, out_data.out_column);
            errors++;
          end
          if (exp_px.out_row !== out_data.out_row) begin
            $error("out_row expected %0d got %0d", exp_px.out_row, out_data.out_row);
            errors++;
          end
          if (exp_px.frame_done !== out_data.frame_done) begin
            $error("frame_done expected %0d got %0d", exp_px.frame_done,
                   out_data.frame_done);
            errors++;
          end
        end
      end
      out_pop <= steady || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_push <= 1'b0;
    in_data <= '0;
    reset_registers();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_clamped_registers();
    test_full_width_row();
    test_back_to_back();
    test_random_frames(830);
    wait_drained();
    $display("Sent %0d pixels, checked %0d averaged pixels over %0d register writes.",
             pixels_sent, pixels_checked, reg_writes);
    $display("Covered clamped sizes, unity and full-width scaling, and random geometries.");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
